/* design/dclf_pkg.sv */
// Shared types and constants for the dollar / carriage-return line framer.
package dclf_pkg;

    localparam int BUF_LEN_DEF = 64;

    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;
    localparam int LEN_W      = 7;

    typedef enum logic [1:0] {
        ACT_RX = 2'd0,
        ACT_TX = 2'd1,
        ACT_WR = 2'd2,
        ACT_RD = 2'd3
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] data_byte;
        logic [5:0] entry_index;
        logic       start_reply;
    } t_item;

    // Ordered so that the packed struct lines up with the output word layout.
    typedef struct packed {
        logic [7:0]       read_data;
        logic [LEN_W-1:0] line_length;
        logic             line_ready;
        logic [7:0]       tx_byte;
        logic             tx_valid;
    } t_result;

endpackage

/* design/dollar_cr_line_uart_framer_top.sv */
// Top level of the dollar / carriage-return command line framer.
//
// One input channel (s) and one output channel (m), stream handshake: a word
// moves on a rising edge with tvalid and tready both high. Every input word
// gives exactly one output word. The input tuser carries the action (received
// byte, transmit tick, host write, host read / start reply); tdata carries the
// byte, the entry index and the start flag.
// A word is accepted and its line buffer read is issued at the same edge; it
// then executes from the stage register with the read data in hand, and its
// result is registered into the output register when that stage advances.
// One word per cycle is sustained while the receiver does not stall; the
// single-port read of the buffer in the accept cycle sets that figure.
// A buffer write by the executing word to the entry the next word reads is
// forwarded around the memory.
// Reset is synchronous, active low, and clears pointers and mode flags; the
// buffer holds no reset value and needs no clearing pass.
// When the receiver stalls, the output register holds its word and one more
// input word is taken into the execute stage before tready drops.
module dollar_cr_line_uart_framer_top #(
    parameter int BUF_LEN = dclf_pkg::BUF_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] data_byte, [13:8] entry_index, [14] start_reply, [15] zero
    input  logic [dclf_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] action
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] line_ready, [16:10] line_length,
    // [24:17] read_data, [31:25] zero
    output logic [dclf_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    localparam int AW = $clog2(BUF_LEN);
    localparam int IW = AW + 6;
    localparam int PAD_W = dclf_pkg::OUT_DATA_W - $bits(dclf_pkg::t_result);

    dclf_pkg::t_item   in_item;
    dclf_pkg::t_item   r_s1_item;
    logic              r_s1_valid;
    logic              r_fwd_hit;
    logic [7:0]        r_fwd_data;
    logic              r_out_valid;
    dclf_pkg::t_result r_out;
    dclf_pkg::t_result result;

    logic              accept;
    logic              s1_adv;
    logic [IW-1:0]     in_idx_ext;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     tx_ptr;
    logic [7:0]        mem_rd_data;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;

    assign in_item.action      = dclf_pkg::t_action'(i_s_tuser);
    assign in_item.data_byte   = i_s_tdata[7:0];
    assign in_item.entry_index = i_s_tdata[13:8];
    assign in_item.start_reply = i_s_tdata[14];

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign accept     = i_s_tvalid && o_s_tready;

    assign in_idx_ext = {{AW{1'b0}}, in_item.entry_index};
    assign rd_addr    = (in_item.action == dclf_pkg::ACT_TX) ? tx_ptr
                                                             : in_idx_ext[AW-1:0];
    assign rd_data    = r_fwd_hit ? r_fwd_data : mem_rd_data;

    dclf_line_mem #(
        .BUF_LEN(BUF_LEN)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_rd_data)
    );

    dclf_exec #(
        .BUF_LEN(BUF_LEN)
    ) u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (s1_adv),
        .i_item    (r_s1_item),
        .i_rd_data (rd_data),
        .o_result  (result),
        .o_tx_ptr  (tx_ptr),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item  <= in_item;
            // memory returns old data on a same-edge write: bypass it
            r_fwd_hit  <= wr_en && (wr_addr == rd_addr);
            r_fwd_data <= wr_data;
        end
        if (s1_adv) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out};

endmodule

/* design/dclf_line_mem.sv */
// Line buffer: one write port, one registered read port.
module dclf_line_mem #(
    parameter int BUF_LEN = dclf_pkg::BUF_LEN_DEF,
    localparam int AW = $clog2(BUF_LEN)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [BUF_LEN];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/dclf_exec.sv */
// Framer control state and the execute step of one word.
module dclf_exec #(
    parameter int BUF_LEN = dclf_pkg::BUF_LEN_DEF,
    localparam int AW = $clog2(BUF_LEN),
    localparam int CW = $clog2(BUF_LEN + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  dclf_pkg::t_item  i_item,
    input  logic [7:0]       i_rd_data,
    output dclf_pkg::t_result o_result,
    output logic [AW-1:0]    o_tx_ptr,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic [7:0]       o_wr_data
);

    localparam int IW = AW + 6;
    localparam int EW = CW + dclf_pkg::LEN_W;

    logic [CW-1:0] r_rx_count, n_rx_count;
    logic [AW-1:0] r_tx_index, n_tx_index;
    logic          r_end_mode, n_end_mode;
    logic          r_rx_en,    n_rx_en;
    logic          r_tx_en,    n_tx_en;

    logic [CW-1:0] cnt_base;
    logic [IW-1:0] idx_ext;
    logic          idx_ok;
    logic          is_cr;
    logic          is_dollar;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] cnt_ext;

    assign is_cr     = (i_item.data_byte == dclf_pkg::CHAR_CR);
    assign is_dollar = (i_item.data_byte == dclf_pkg::CHAR_DOLLAR);
    assign idx_ext   = {{AW{1'b0}}, i_item.entry_index};
    assign idx_ok    = (idx_ext < IW'(BUF_LEN));
    assign cnt_base  = is_dollar ? '0 : r_rx_count;

    always_comb begin
        n_rx_count = r_rx_count;
        n_tx_index = r_tx_index;
        n_end_mode = r_end_mode;
        n_rx_en    = r_rx_en;
        n_tx_en    = r_tx_en;
        wr_en      = 1'b0;
        wr_addr    = idx_ext[AW-1:0];
        o_result   = '0;
        unique case (i_item.action)
            dclf_pkg::ACT_RX: begin
                if (r_rx_en) begin
                    if (r_end_mode) begin
                        if (is_cr) begin
                            n_end_mode = 1'b0;
                            n_rx_count = '0;
                            n_tx_index = '0;
                        end
                    end else if (r_rx_count != '0 || is_dollar) begin
                        // full buffer: drop the line
                        if (cnt_base == CW'(BUF_LEN)) begin
                            n_rx_count = '0;
                        end else if (!is_cr) begin
                            wr_en      = 1'b1;
                            wr_addr    = cnt_base[AW-1:0];
                            n_rx_count = cnt_base + 1'b1;
                        end else begin
                            o_result.line_ready = 1'b1;
                            n_rx_en             = 1'b0;
                        end
                    end
                end
            end
            dclf_pkg::ACT_TX: begin
                if (r_tx_en) begin
                    o_result.tx_valid = 1'b1;
                    o_result.tx_byte  = i_rd_data;
                    if (i_rd_data == dclf_pkg::CHAR_CR) begin
                        n_rx_en    = 1'b1;
                        n_tx_en    = 1'b0;
                        n_end_mode = 1'b1;
                    end
                    n_tx_index = (r_tx_index == AW'(BUF_LEN - 1)) ? '0
                                                                  : r_tx_index + 1'b1;
                end
            end
            dclf_pkg::ACT_WR: begin
                wr_en = idx_ok;
            end
            dclf_pkg::ACT_RD: begin
                o_result.read_data = idx_ok ? i_rd_data : 8'd0;
                if (i_item.start_reply) begin
                    n_tx_en = 1'b1;
                end
            end
            default: ;
        endcase
        cnt_ext              = {{dclf_pkg::LEN_W{1'b0}}, n_rx_count};
        o_result.line_length = cnt_ext[dclf_pkg::LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count <= '0;
            r_tx_index <= '0;
            r_end_mode <= 1'b0;
            r_rx_en    <= 1'b1;
            r_tx_en    <= 1'b0;
        end else if (i_adv) begin
            r_rx_count <= n_rx_count;
            r_tx_index <= n_tx_index;
            r_end_mode <= n_end_mode;
            r_rx_en    <= n_rx_en;
            r_tx_en    <= n_tx_en;
        end
    end

    // pointer the following word will see
    assign o_tx_ptr  = i_adv ? n_tx_index : r_tx_index;
    assign o_wr_en   = i_adv && wr_en;
    assign o_wr_addr = wr_addr;
    assign o_wr_data = i_item.data_byte;

endmodule

/* design/dclf_checker.sv */
// Port-level checks for the line framer, bound to the top level.
module dclf_port_checks #(
    parameter int BUF_LEN = dclf_pkg::BUF_LEN_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [dclf_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input logic [1:0]                      i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [dclf_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[8:1] == 8'd0)
        else $error("tx byte nonzero without tx valid");

    a_ready_tx_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[9]))
        else $error("line ready and tx valid on the same word");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (BUF_LEN >= 128) || (o_m_tdata[16:10] <= 7'(BUF_LEN)))
        else $error("line length beyond buffer length");

endmodule

bind dollar_cr_line_uart_framer_top dclf_port_checks #(.BUF_LEN(BUF_LEN)) u_chk (.*);
